[src/afs_pkg.sv]
`timescale 1ns / 1ps
// Package for the animation frame sequencer: sizes, constants and the command codes.
// Has no dependencies; the sequencer and its checker use it by scoped names.
package afs_pkg;

	// Frame table size and default display time
	localparam int MAX_FRAMES       = 64;
	localparam int SLOT_W           = 6;
	localparam int FRAME_W          = 7;
	localparam int MS_W             = 16;
	localparam int TIME_W           = 18;
	localparam int DEFAULT_FRAME_MS = 20;

	// Stream widths in bits
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;

	// Command codes carried on the input tuser
	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_PLAY    = 3'd1,
		CMD_PAUSE   = 3'd2,
		CMD_RESTART = 3'd3,
		CMD_WRITE   = 3'd4
	} cmd_t;

endpackage

[src/animation_frame_sequencer.sv]
`timescale 1ns / 1ps
// Animation frame sequencer: steps a sprite animation through a table of frame times.
// Depends on afs_pkg. Holds the frame duration table as an internal memory.
//
//  channel   | direction | per transfer
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | one command: tick, play, pause, restart, write duration
//  m_axis    | out       | one status result for every command taken
//  cfg       | in        | frame count write, no handshake
//
// One command per cycle while m_axis takes its results. A command is held in an input
// register and, once the result slot is free, worked into the result register.
// The duration of the next frame is fetched ahead from the table's registered read port,
// so every command can follow the previous one directly.
// Reset clears play state, frame number, time left and both valid flags; the
// table is not cleared. A stalled m_axis holds its result and stops the input.
module animation_frame_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [afs_pkg::FRAME_W-1:0]     cfg_wr_data,   // frame_count
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [afs_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // elapsed_ms[15:0], frame_slot[21:16],
	                                                       // duration_ms[37:22], zeros
	input  logic [afs_pkg::IN_USER_W-1:0]   s_axis_tuser,  // command[2:0]
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [afs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // frame_number[6:0], frame_advanced[7],
	                                                       // is_playing[8], zeros
	output logic                            m_axis_tlast   // action_done
);

	localparam logic signed [afs_pkg::TIME_W-1:0] TL_MIN =
		{1'b1, {(afs_pkg::TIME_W-1){1'b0}}};
	localparam logic [afs_pkg::MS_W-1:0] DEF_MS = afs_pkg::MS_W'(afs_pkg::DEFAULT_FRAME_MS);

	// Configuration register
	logic [afs_pkg::FRAME_W-1:0] frame_count_q;

	// Input register
	logic                        valid_s1;
	afs_pkg::cmd_t               cmd_s1;
	logic [afs_pkg::MS_W-1:0]    elapsed_s1;
	logic [afs_pkg::SLOT_W-1:0]  slot_s1;
	logic [afs_pkg::MS_W-1:0]    dur_s1;

	// Sequencer state
	logic                               playing_q;
	logic [afs_pkg::FRAME_W-1:0]        pos_q;
	logic signed [afs_pkg::TIME_W-1:0]  tl_q;

	// Duration table, first-entry copy and look-ahead read
	logic [afs_pkg::MS_W-1:0]    dur_mem [afs_pkg::MAX_FRAMES];
	logic [afs_pkg::MS_W-1:0]    dur0_q;
	logic [afs_pkg::MS_W-1:0]    next_dur_q;
	logic [afs_pkg::SLOT_W-1:0]  rd_addr;

	// Result register
	logic                        out_valid_q;
	logic [afs_pkg::FRAME_W-1:0] out_pos_q;
	logic                        out_adv_q;
	logic                        out_done_q;
	logic                        out_play_q;

	// Combinational work
	logic                               work;
	logic                               wr_en;
	logic                               playing_d;
	logic [afs_pkg::FRAME_W-1:0]        pos_d;
	logic signed [afs_pkg::TIME_W-1:0]  tl_d;
	logic                               adv_d;
	logic                               done_d;
	logic signed [afs_pkg::TIME_W:0]    diff;
	logic signed [afs_pkg::TIME_W-1:0]  tl_sub;
	logic [afs_pkg::FRAME_W-1:0]        pos_inc;
	logic [afs_pkg::FRAME_W-1:0]        pos_tick;
	logic [afs_pkg::MS_W-1:0]           first_ms;
	logic [afs_pkg::MS_W-1:0]           inc_ms;

	// Handshake: work when an item waits and the result slot is free or leaving
	assign work          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || work;
	assign wr_en         = work && (cmd_s1 == afs_pkg::CMD_WRITE);

	// Duration of frame 0 and of the frame after the current one
	assign pos_inc  = pos_q + 1'b1;
	assign first_ms = (frame_count_q != '0) ? dur0_q : DEF_MS;
	assign inc_ms   = ((pos_inc < frame_count_q) && (32'(pos_inc) < afs_pkg::MAX_FRAMES))
		? next_dur_q : DEF_MS;

	// Time left after the tick, held at the bottom of its range
	assign diff   = {tl_q[afs_pkg::TIME_W-1], tl_q} - $signed({3'b000, elapsed_s1});
	assign tl_sub = (diff[afs_pkg::TIME_W] != diff[afs_pkg::TIME_W-1])
		? TL_MIN : diff[afs_pkg::TIME_W-1:0];

	// Next state and result flags
	always_comb begin
		playing_d = playing_q;
		pos_d     = pos_q;
		tl_d      = tl_q;
		adv_d     = 1'b0;
		done_d    = 1'b0;
		pos_tick  = pos_q;
		case (cmd_s1)
			afs_pkg::CMD_TICK: begin
				if (playing_q) begin
					tl_d = tl_sub;
					if (tl_sub[afs_pkg::TIME_W-1] || (tl_sub == '0)) begin
						pos_tick = pos_inc;
						tl_d     = $signed({2'b00, inc_ms});
						adv_d    = 1'b1;
					end
					pos_d = pos_tick;
					if (pos_tick >= frame_count_q) begin
						pos_d  = '0;
						tl_d   = $signed({2'b00, first_ms});
						done_d = 1'b1;
					end
				end
			end
			afs_pkg::CMD_PLAY: begin
				playing_d = 1'b1;
				pos_d     = '0;
				tl_d      = $signed({2'b00, first_ms});
			end
			afs_pkg::CMD_PAUSE: begin
				playing_d = 1'b0;
			end
			afs_pkg::CMD_RESTART: begin
				pos_d = '0;
				tl_d  = $signed({2'b00, first_ms});
			end
			default: begin
			end
		endcase
	end

	// Look-ahead address: the frame after the one that holds from the next cycle on
	always_comb begin
		logic [afs_pkg::FRAME_W-1:0] pos_next;
		logic [afs_pkg::FRAME_W-1:0] pos_next_inc;
		pos_next     = work ? pos_d : pos_q;
		pos_next_inc = pos_next + 1'b1;
		rd_addr      = pos_next_inc[afs_pkg::SLOT_W-1:0];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (cfg_wr_en) begin
			frame_count_q <= cfg_wr_data;
		end
	end

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1     <= afs_pkg::cmd_t'(s_axis_tuser);
			elapsed_s1 <= s_axis_tdata[15:0];
			slot_s1    <= s_axis_tdata[21:16];
			dur_s1     <= s_axis_tdata[37:22];
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			pos_q     <= '0;
			tl_q      <= '0;
		end else if (work) begin
			playing_q <= playing_d;
			pos_q     <= pos_d;
			tl_q      <= tl_d;
		end
	end

	// Duration table write, first-entry copy
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dur_mem[slot_s1] <= dur_s1;
			if (slot_s1 == '0) begin
				dur0_q <= dur_s1;
			end
		end
	end

	// Registered table read, with the write of the same edge passed through
	always_ff @(posedge clk) begin
		if (wr_en && (slot_s1 == rd_addr)) begin
			next_dur_q <= dur_s1;
		end else begin
			next_dur_q <= dur_mem[rd_addr];
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (work) begin
			out_pos_q  <= pos_d;
			out_adv_q  <= adv_d;
			out_done_q <= done_d;
			out_play_q <= playing_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0000000, out_play_q, out_adv_q, out_pos_q};
	assign m_axis_tlast  = out_done_q;

endmodule

[src/afs_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the animation frame sequencer, with its bind statement.
// Depends on afs_pkg and on the port list of animation_frame_sequencer.
module afs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tready,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [afs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            m_axis_tlast
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A wrap always lands on frame 0
	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[6:0] == 7'd0)
		else $error("action done without frame 0");

	// Frame moves and wraps only happen while playing
	a_move_playing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[7] || m_axis_tlast) |-> m_axis_tdata[8])
		else $error("frame moved while paused");

	// With the result slot empty the input is never held off
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result slot");

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for animation_frame_sequencer: random and directed command streams,
// with bursty input, stalling output and a command-level frame timer predictor.
// Depends on afs_pkg and the animation_frame_sequencer RTL only.
module tb;

	localparam int          TL_MAX       = 131071;
	localparam int          TL_MIN       = -131072;
	localparam int          LONG_HOLD    = 300;
	localparam int          CYCLE_LIMIT  = 300000;
	localparam int          SETTLE       = 10;
	localparam logic [2:0]  CMD_BOGUS_LO = 3'd5;

	// One command as it travels on s_axis
	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] elapsed;
		logic [5:0]  slot;
		logic [15:0] dur;
	} anim_cmd_t;

	// One status word as it travels on m_axis
	typedef struct packed {
		logic [6:0] frame;
		logic       advanced;
		logic       done;
		logic       playing;
	} frame_status_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [afs_pkg::FRAME_W-1:0]     cfg_wr_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [afs_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [afs_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [afs_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic                            m_axis_tlast;

	animation_frame_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: a private copy of the sequencer
	logic [6:0]  anim_frames = '0;
	logic        anim_playing = 1'b0;
	logic [6:0]  anim_pos = '0;
	int          anim_left = 0;
	logic [15:0] anim_table [afs_pkg::MAX_FRAMES];

	anim_cmd_t     cmd_backlog [$];
	frame_status_t status_due [$];
	int            faults = 0;
	int            hold_asks = 0;

	function automatic int frame_time(logic [6:0] f);
		if (f < anim_frames && f < afs_pkg::MAX_FRAMES)
			return int'(anim_table[f[5:0]]);
		return afs_pkg::DEFAULT_FRAME_MS;
	endfunction

	// Apply one command to the predictor and return the status it should produce
	function automatic frame_status_t advance_animation(anim_cmd_t c);
		frame_status_t st;
		int left;
		st = '0;
		case (c.cmd)
			afs_pkg::CMD_TICK: begin
				if (anim_playing) begin
					left = anim_left - int'(c.elapsed);
					if (left > TL_MAX)
						left = TL_MAX;
					if (left < TL_MIN)
						left = TL_MIN;
					anim_left = left;
					// at most one advance per tick, however long the tick
					if (anim_left <= 0) begin
						anim_pos = anim_pos + 7'd1;
						anim_left = frame_time(anim_pos);
						st.advanced = 1'b1;
					end
					if (anim_pos >= anim_frames) begin
						anim_pos = '0;
						anim_left = frame_time('0);
						st.done = 1'b1;
					end
				end
			end
			afs_pkg::CMD_PLAY: begin
				anim_playing = 1'b1;
				anim_pos = '0;
				anim_left = frame_time('0);
			end
			afs_pkg::CMD_PAUSE: begin
				anim_playing = 1'b0;
			end
			afs_pkg::CMD_RESTART: begin
				anim_pos = '0;
				anim_left = frame_time('0);
			end
			afs_pkg::CMD_WRITE: begin
				anim_table[c.slot] = c.dur;
			end
			default: begin
			end
		endcase
		st.frame = anim_pos;
		st.playing = anim_playing;
		return st;
	endfunction

	function automatic anim_cmd_t mk(logic [2:0] cmd, logic [15:0] elapsed, logic [5:0] slot,
			logic [15:0] dur);
		anim_cmd_t c;
		c.cmd = cmd;
		c.elapsed = elapsed;
		c.slot = slot;
		c.dur = dur;
		return c;
	endfunction

	// Mostly short times so frames turn over often; now and then the full range
	function automatic logic [15:0] rnd_ms(int short_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(0, short_max));
		if (r < 90)
			return 16'($urandom_range(0, 2000));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic anim_cmd_t rnd_cmd();
		anim_cmd_t c;
		int r;
		c = mk(afs_pkg::CMD_TICK, rnd_ms(30), 6'($urandom_range(0, 63)), rnd_ms(40));
		r = $urandom_range(0, 99);
		if (r >= 62 && r < 70)
			c.cmd = afs_pkg::CMD_PLAY;
		else if (r >= 70 && r < 75)
			c.cmd = afs_pkg::CMD_PAUSE;
		else if (r >= 75 && r < 80)
			c.cmd = afs_pkg::CMD_RESTART;
		else if (r >= 80 && r < 94)
			c.cmd = afs_pkg::CMD_WRITE;
		else if (r >= 94)
			c.cmd = CMD_BOGUS_LO + 3'($urandom_range(0, 2));
		return c;
	endfunction

	// Sender: bursts of transfers separated by random gaps
	anim_cmd_t on_offer = '0;
	int        burst_left = 1;
	int        gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		logic offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				status_due.push_back(advance_animation(on_offer));
			offer = s_axis_tvalid && !s_axis_tready;
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					on_offer = cmd_backlog.pop_front();
					offer = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 9) == 0) begin
						burst_left = 150;
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			s_axis_tvalid <= offer;
			s_axis_tdata <= {2'b00, on_offer.dur, on_offer.slot, on_offer.elapsed};
			s_axis_tuser <= on_offer.cmd;
		end
	end

	// Receiver: a random stall mode, drawn anew when its count runs out; a long hold when asked
	int hold_seen = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = 64;
			end
			rx_mode_left--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				2: m_axis_tready <= ($urandom_range(0, 4) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: each status transfer against the oldest prediction
	always @(posedge clk) begin
		frame_status_t got;
		frame_status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.frame = m_axis_tdata[6:0];
			got.advanced = m_axis_tdata[7];
			got.playing = m_axis_tdata[8];
			got.done = m_axis_tlast;
			if (status_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected status: frame %0d adv %0b done %0b play %0b",
						got.frame, got.advanced, got.done, got.playing);
			end else begin
				want = status_due.pop_front();
				if (got != want) begin
					faults++;
					if (faults <= 10)
						$display("status mismatch (exp/act): frame %0d/%0d adv %0b/%0b done %0b/%0b play %0b/%0b",
							want.frame, got.frame, want.advanced, got.advanced,
							want.done, got.done, want.playing, got.playing);
				end
			end
		end
	end

	// Run limit
	int cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[animation_frame_sequencer] ERROR");
			$finish;
		end
	end

	// Nothing in flight: backlog drained, input quiet, every status seen
	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || s_axis_tvalid || status_due.size() != 0);
	endtask

	task automatic set_frames(logic [6:0] n);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		anim_frames = n;
	endtask

	task automatic run_phase(logic [6:0] n, int count, bit long_hold);
		wait_idle();
		repeat (4) @(posedge clk);
		set_frames(n);
		if (long_hold)
			hold_asks++;
		repeat (count)
			cmd_backlog.push_back(rnd_cmd());
	endtask

	// Stimulus: directed opening, table fill, then random phases
	initial begin
		logic [6:0] plan [10];
		plan = '{7'd64, 7'd1, 7'd3, 7'd64, 7'd0, 7'd2, 7'd63, 7'd10, 7'd64, 7'd5};
		plan[7] = 7'($urandom_range(4, 60));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		set_frames(7'd0);

		// empty animation: only the default time is ever read
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(CMD_BOGUS_LO, 16'hffff, 6'h3f, 16'hffff));
		cmd_backlog.push_back(mk(CMD_BOGUS_LO + 3'd2, 16'hffff, 6'h3f, 16'hffff));
		cmd_backlog.push_back(mk(afs_pkg::CMD_WRITE, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_WRITE, 16'd0, 6'd63, 16'hffff));
		cmd_backlog.push_back(mk(afs_pkg::CMD_WRITE, 16'd0, 6'd1, 16'd1));
		cmd_backlog.push_back(mk(afs_pkg::CMD_PLAY, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'hffff, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'd19, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_PAUSE, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'hffff, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_RESTART, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_PLAY, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_RESTART, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'h5555, 6'h2a, 16'haaaa));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'haaaa, 6'h15, 16'h5555));

		// every table entry written before any frame count lets it be read
		for (int i = 0; i < afs_pkg::MAX_FRAMES; i++)
			cmd_backlog.push_back(mk(afs_pkg::CMD_WRITE, rnd_ms(30), 6'(i), rnd_ms(40)));

		// first phase at full size: play, then a tick that runs far past its frame
		wait_idle();
		set_frames(7'd64);
		cmd_backlog.push_back(mk(afs_pkg::CMD_PLAY, 16'd0, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'hffff, 6'd0, 16'd0));
		cmd_backlog.push_back(mk(afs_pkg::CMD_TICK, 16'd0, 6'd0, 16'd0));

		foreach (plan[i])
			run_phase(plan[i], 85, i == 3);

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		faults += status_due.size();
		if (faults == 0)
			$display("[animation_frame_sequencer] OK");
		else
			$display("[animation_frame_sequencer] ERROR");
		$finish;
	end

endmodule
